// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define AST_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check that a condition in one cycle implies another in the next.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/sat_pkg.sv -----
package sat_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int MASK_W      = SLOTS + 1;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] KIND_PERIODIC  = 2'd0;
  localparam logic [1:0] KIND_DAILY     = 2'd1;
  localparam logic [1:0] KIND_CONDITION = 2'd2;
  localparam logic [1:0] KIND_ONESHOT   = 2'd3;

  localparam logic [2:0] RES_CREATED   = 3'd0;
  localparam logic [2:0] RES_REJECTED  = 3'd1;
  localparam logic [2:0] RES_DELETED   = 3'd2;
  localparam logic [2:0] RES_NOT_FOUND = 3'd3;
  localparam logic [2:0] RES_FIRED     = 3'd4;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  typedef struct packed {
    logic [7:0]  alarm_id;
    logic [1:0]  kind;
    logic [15:0] interval;
    logic [4:0]  hour;
    logic [7:0]  minute;
    logic [31:0] last_fire;
    logic [15:0] action;
  } slot_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_seconds;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
    logic [5:0]  local_second;
    logic        clock_synced;
    logic [1:0]  schedule_kind;
    logic [15:0] period_or_hour;
    logic [7:0]  minute_of_hour;
    logic [7:0]  entry_id;
    logic [15:0] action_tag;
  } req_t;

  typedef struct packed {
    logic       tick;
    logic       del;
    logic       del_armed;
    logic       write_here;
    logic [7:0] new_id;
  } ctl_t;

endpackage

// ----- rtl/core/sat_cell.sv -----
module sat_cell import sat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t rec_in,
  output slot_t rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (shift) begin
      rec <= rec_in;
    end
  end

endmodule

// ----- rtl/core/sat_eval.sv -----
module sat_eval import sat_pkg::*; (
  input  slot_t rec,
  input  req_t  req,
  input  ctl_t  ctl,
  output slot_t rec_next,
  output logic  fire,
  output logic  del_hit
);

  logic [21:0] wait_s;
  logic [31:0] elapsed;
  logic [31:0] minute_base;
  logic        timed;

  always_comb begin
    // interval * 60 as (x << 6) - (x << 2)
    wait_s       = {rec.interval, 6'b0} - {4'b0, rec.interval, 2'b0};
    elapsed      = req.now_seconds - rec.last_fire;
    minute_base  = req.now_seconds - {26'b0, req.local_second};
    timed        = (rec.kind == KIND_PERIODIC) || (rec.kind == KIND_ONESHOT);
    fire         = 1'b0;
    if (ctl.tick && rec.alarm_id != 8'd0) begin
      if (timed) begin
        fire = (req.now_seconds >= rec.last_fire) && (elapsed >= {10'b0, wait_s});
      end else if (rec.kind == KIND_DAILY && req.clock_synced) begin
        fire = (req.local_hour == rec.hour) && ({2'b0, req.local_minute} == rec.minute)
               && (rec.last_fire < minute_base);
      end
    end
    del_hit  = ctl.del && ctl.del_armed && (rec.alarm_id == req.entry_id);
    rec_next = rec;
    if (fire) begin
      if (rec.kind == KIND_ONESHOT) begin
        rec_next.alarm_id = 8'd0;
      end else begin
        rec_next.last_fire = req.now_seconds;
      end
    end
    if (del_hit) begin
      rec_next.alarm_id = 8'd0;
    end
    if (ctl.write_here) begin
      rec_next.alarm_id  = ctl.new_id;
      rec_next.kind      = req.schedule_kind;
      rec_next.action    = req.action_tag;
      rec_next.last_fire = (req.schedule_kind == KIND_ONESHOT) ? req.now_seconds : 32'd0;
      if (req.schedule_kind == KIND_PERIODIC || req.schedule_kind == KIND_ONESHOT) begin
        rec_next.interval = req.period_or_hour;
        rec_next.hour     = 5'd0;
        rec_next.minute   = 8'd0;
      end else begin
        rec_next.interval = 16'd0;
        rec_next.hour     = req.period_or_hour[4:0];
        rec_next.minute   = req.minute_of_hour;
      end
    end
  end

endmodule

// ----- rtl/core/scheduled_alarm_table_top.sv -----
// Alarm table with SLOTS slots held in a ring of cells.
// Input channel (in_valid/in_ready) takes one request word: tick, create or
// delete. Output channel (out_valid/out_ready) returns result words; the last
// word of a request has last_of_run set. A quiet tick and opcode 3 give none.
// Config writes (cfg_we, cfg_index, cfg_data) set the interval bounds and take
// effect at once; write them only while the block is idle.
// The ring rotates one slot per cycle, unless the output stalls, past a single
// evaluation stage. Tick and delete make one pass round the ring; create makes
// one pass to find the free slot and id, then a pick step, then one pass to
// write; a rejected create skips the write pass.
// One request is in flight at a time; in_ready is high only when idle.
// Firings of a tick stream out while the ring rotates.
// When the receiver stalls, the ring freezes until the output word is taken;
// the held word stays unchanged.
// Synchronous reset frees all slots, restores the bounds to 1 and 65535 and
// drops any word in flight.
module scheduled_alarm_table_top import sat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] now_seconds,
  input  logic [4:0]  local_hour,
  input  logic [5:0]  local_minute,
  input  logic [5:0]  local_second,
  input  logic        clock_synced,
  input  logic [1:0]  schedule_kind,
  input  logic [15:0] period_or_hour,
  input  logic [7:0]  minute_of_hour,
  input  logic [7:0]  entry_id,
  input  logic [15:0] action_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  alarm_id,
  output logic [15:0] fired_action,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PICK = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state;
  req_t              req;
  logic [15:0]       min_iv;
  logic [15:0]       max_iv;
  logic [IDX_W-1:0]  step;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [MASK_W-1:0] used_mask;
  logic [7:0]        new_id;
  logic [7:0]        new_id_next;
  logic              create_ok;
  logic              checks_ok;
  logic              del_found;
  logic              pend_valid;
  logic [7:0]        pend_id;
  logic [15:0]       pend_act;
  logic [CNT_W-1:0]  res_cnt;

  slot_t cells [SLOTS];
  slot_t head_next;
  ctl_t  ctl;
  logic  fire;
  logic  del_hit;
  logic  out_free;
  logic  advance;
  logic  pass_end;
  logic  record;
  logic  out_load;

  assign out_free = !out_valid || out_ready;
  assign advance  = (state == S_SCAN || state == S_FILL) && out_free;
  assign pass_end = (step == IDX_W'(SLOTS - 1));
  assign in_ready = (state == S_IDLE);
  assign record   = fire && (res_cnt < CNT_W'(MAX_RESULTS));

  always_comb begin
    ctl.tick       = (state == S_SCAN) && (req.opcode == OP_TICK);
    ctl.del        = (state == S_SCAN) && (req.opcode == OP_DELETE);
    ctl.del_armed  = !del_found;
    ctl.write_here = (state == S_FILL) && (step == free_idx);
    ctl.new_id     = new_id;
  end

  sat_eval u_eval (
    .rec      (cells[0]),
    .req      (req),
    .ctl      (ctl),
    .rec_next (head_next),
    .fire     (fire),
    .del_hit  (del_hit)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    slot_t rec_in;
    if (i == SLOTS - 1) begin : g_tail
      assign rec_in = head_next;
    end else begin : g_mid
      assign rec_in = cells[i+1];
    end
    sat_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (advance),
      .rec_in (rec_in),
      .rec    (cells[i])
    );
  end

  always_comb begin
    checks_ok = (req.action_tag != 16'd0);
    if (req.schedule_kind == KIND_PERIODIC || req.schedule_kind == KIND_ONESHOT) begin
      if (req.period_or_hour < min_iv || req.period_or_hour > max_iv) begin
        checks_ok = 1'b0;
      end
    end
    if (req.schedule_kind == KIND_DAILY) begin
      if (req.period_or_hour > 16'd23 || req.minute_of_hour > 8'd59) begin
        checks_ok = 1'b0;
      end
    end
  end

  // lowest id not in use
  always_comb begin
    new_id_next = 8'd0;
    for (int j = MASK_W - 1; j >= 0; j--) begin
      if (!used_mask[j]) begin
        new_id_next = 8'(j + 1);
      end
    end
  end

  // a word is loaded into the output register here
  always_comb begin
    out_load = advance && record && pend_valid;
    if (state == S_DONE && out_free) begin
      case (req.opcode)
        OP_CREATE: out_load = 1'b1;
        OP_DELETE: out_load = 1'b1;
        OP_TICK:   out_load = pend_valid;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_iv <= 16'd1;
      max_iv <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN: min_iv <= cfg_data;
        CFG_MAX: max_iv <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      free_found <= 1'b0;
      del_found  <= 1'b0;
      pend_valid <= 1'b0;
      res_cnt    <= '0;
      create_ok  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req.opcode         <= opcode;
            req.now_seconds    <= now_seconds;
            req.local_hour     <= local_hour;
            req.local_minute   <= local_minute;
            req.local_second   <= local_second;
            req.clock_synced   <= clock_synced;
            req.schedule_kind  <= schedule_kind;
            req.period_or_hour <= period_or_hour;
            req.minute_of_hour <= minute_of_hour;
            req.entry_id       <= entry_id;
            req.action_tag     <= action_tag;
            step       <= '0;
            free_found <= 1'b0;
            del_found  <= 1'b0;
            pend_valid <= 1'b0;
            res_cnt    <= '0;
            used_mask  <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            if (cells[0].alarm_id == 8'd0 && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= step;
            end
            for (int j = 0; j < MASK_W; j++) begin
              if (cells[0].alarm_id == 8'(j + 1)) begin
                used_mask[j] <= 1'b1;
              end
            end
            if (del_hit) begin
              del_found <= 1'b1;
            end
            if (record) begin
              // push the held firing out, keep the new one until the next
              if (pend_valid) begin
                result_kind  <= RES_FIRED;
                alarm_id     <= pend_id;
                fired_action <= pend_act;
                last_of_run  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= cells[0].alarm_id;
              pend_act   <= cells[0].action;
              res_cnt    <= res_cnt + CNT_W'(1);
            end
            if (pass_end) begin
              step  <= '0;
              state <= (req.opcode == OP_CREATE) ? S_PICK : S_DONE;
            end else begin
              step <= step + IDX_W'(1);
            end
          end
        end
        S_PICK: begin
          new_id    <= new_id_next;
          create_ok <= checks_ok && free_found;
          state     <= (checks_ok && free_found) ? S_FILL : S_DONE;
        end
        S_FILL: begin
          if (advance) begin
            if (pass_end) begin
              step  <= '0;
              state <= S_DONE;
            end else begin
              step <= step + IDX_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            case (req.opcode)
              OP_CREATE: begin
                result_kind  <= create_ok ? RES_CREATED : RES_REJECTED;
                alarm_id     <= create_ok ? new_id : 8'd0;
                fired_action <= 16'd0;
                last_of_run  <= 1'b1;
                create_ok    <= 1'b0;
              end
              OP_DELETE: begin
                result_kind  <= del_found ? RES_DELETED : RES_NOT_FOUND;
                alarm_id     <= del_found ? req.entry_id : 8'd0;
                fired_action <= 16'd0;
                last_of_run  <= 1'b1;
              end
              OP_TICK: begin
                if (pend_valid) begin
                  result_kind  <= RES_FIRED;
                  alarm_id     <= pend_id;
                  fired_action <= pend_act;
                  last_of_run  <= 1'b1;
                end
                pend_valid <= 1'b0;
              end
              default: ;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/sat_chk.sv -----
`include "assert_macros.svh"

module sat_chk import sat_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  result_kind,
  input logic [7:0]  alarm_id,
  input logic [15:0] fired_action,
  input logic        last_of_run
);

  logic is_fired;
  logic no_id;

  assign is_fired = (result_kind == RES_FIRED);
  assign no_id    = (result_kind == RES_REJECTED) || (result_kind == RES_NOT_FOUND);

  `AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `AST_HOLDS(a_action_only_fired, !out_valid || is_fired || fired_action == 16'd0)
  `AST_HOLDS(a_reject_id_zero, !out_valid || !no_id || alarm_id == 8'd0)
  `AST_HOLDS(a_single_word_last, !out_valid || is_fired || last_of_run)
  `AST_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(alarm_id) && $stable(result_kind))

endmodule

bind scheduled_alarm_table_top sat_chk u_sat_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .alarm_id     (alarm_id),
  .fired_action (fired_action),
  .last_of_run  (last_of_run)
);

// ----- bench/tb.sv -----
module tb;
  import sat_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [15:0] action;
    logic        last;
  } alarm_word_t;

  typedef struct packed {
    req_t       req;
    logic       typed;
    logic [2:0] want_kind;
    logic [7:0] want_id;
  } stim_row_t;

  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [31:0] now_seconds;
  logic [4:0]  local_hour;
  logic [5:0]  local_minute;
  logic [5:0]  local_second;
  logic        clock_synced;
  logic [1:0]  schedule_kind;
  logic [15:0] period_or_hour;
  logic [7:0]  minute_of_hour;
  logic [7:0]  entry_id;
  logic [15:0] action_tag;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  result_kind;
  logic [7:0]  alarm_id;
  logic [15:0] fired_action;
  logic        last_of_run;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  scheduled_alarm_table_top i_dut (.*);

  // table copy kept by the bench
  slot_t       shadow [SLOTS];
  logic [15:0] bound_min;
  logic [15:0] bound_max;
  alarm_word_t pending_words [$];
  int          mismatches;
  logic [31:0] epoch;
  int          burst_left;
  int          gap_max;
  int          stall_left;
  bit          stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("scheduled_alarm_table_top verification failed");
    $finish;
  end

  function automatic void push_word(logic [2:0] k, logic [7:0] id, logic [15:0] act,
                                    logic last);
    alarm_word_t w;
    w.kind = k;
    w.id = id;
    w.action = act;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  function automatic logic [7:0] create_alarm(req_t r);
    int          slot;
    logic [7:0]  id;
    bit          used;
    slot = -1;
    if (r.action_tag == 16'd0) return 8'd0;
    if ((r.schedule_kind == KIND_PERIODIC || r.schedule_kind == KIND_ONESHOT) &&
        (r.period_or_hour < bound_min || r.period_or_hour > bound_max)) return 8'd0;
    if (r.schedule_kind == KIND_DAILY &&
        (r.period_or_hour > 16'd23 || r.minute_of_hour > 8'd59)) return 8'd0;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && shadow[i].alarm_id == 8'd0) slot = i;
    if (slot < 0) return 8'd0;
    id = 8'd0;
    for (int c = 1; c < 256 && id == 8'd0; c++) begin
      used = 1'b0;
      for (int i = 0; i < SLOTS; i++)
        if (shadow[i].alarm_id == 8'(c)) used = 1'b1;
      if (!used) id = 8'(c);
    end
    if (id == 8'd0) return 8'd0;
    shadow[slot].alarm_id = id;
    shadow[slot].kind = r.schedule_kind;
    shadow[slot].last_fire = (r.schedule_kind == KIND_ONESHOT) ? r.now_seconds : 32'd0;
    shadow[slot].action = r.action_tag;
    if (r.schedule_kind == KIND_PERIODIC || r.schedule_kind == KIND_ONESHOT) begin
      shadow[slot].interval = r.period_or_hour;
      shadow[slot].hour = 5'd0;
      shadow[slot].minute = 8'd0;
    end else begin
      shadow[slot].interval = 16'd0;
      shadow[slot].hour = r.period_or_hour[4:0];
      shadow[slot].minute = r.minute_of_hour;
    end
    return id;
  endfunction

  function automatic void predict_request(req_t r);
    int          fired;
    bit          fire;
    bit          found;
    logic [31:0] wait_s;
    logic [31:0] minute_base;
    logic [7:0]  id;
    fired = 0;
    found = 1'b0;
    case (r.opcode)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          fire = 1'b0;
          if (shadow[i].alarm_id != 8'd0) begin
            if (shadow[i].kind == KIND_PERIODIC || shadow[i].kind == KIND_ONESHOT) begin
              wait_s = 32'(shadow[i].interval) * 32'd60;
              if (r.now_seconds >= shadow[i].last_fire &&
                  r.now_seconds - shadow[i].last_fire >= wait_s) fire = 1'b1;
            end else if (shadow[i].kind == KIND_DAILY && r.clock_synced) begin
              minute_base = r.now_seconds - 32'(r.local_second);
              if (r.local_hour == shadow[i].hour &&
                  8'(r.local_minute) == shadow[i].minute &&
                  shadow[i].last_fire < minute_base) fire = 1'b1;
            end
          end
          if (fire) begin
            if (fired < MAX_RESULTS) begin
              push_word(RES_FIRED, shadow[i].alarm_id, shadow[i].action, 1'b0);
              fired++;
            end
            if (shadow[i].kind == KIND_ONESHOT) shadow[i].alarm_id = 8'd0;
            else shadow[i].last_fire = r.now_seconds;
          end
        end
        if (fired > 0) pending_words[$].last = 1'b1;
      end
      OP_CREATE: begin
        id = create_alarm(r);
        push_word(id != 8'd0 ? RES_CREATED : RES_REJECTED, id, 16'd0, 1'b1);
      end
      OP_DELETE: begin
        for (int i = 0; i < SLOTS; i++)
          if (!found && shadow[i].alarm_id == r.entry_id) begin
            shadow[i].alarm_id = 8'd0;
            found = 1'b1;
          end
        if (found) push_word(RES_DELETED, r.entry_id, 16'd0, 1'b1);
        else push_word(RES_NOT_FOUND, 8'd0, 16'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // hand one request word to the block, with burst gaps ahead of it;
  // valid stays up on return, so follow with another request or settle_idle
  task automatic send_request(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    {opcode, now_seconds, local_hour, local_minute, local_second, clock_synced,
     schedule_kind, period_or_hour, minute_of_hour, entry_id, action_tag} <= r;
    do @(posedge clk); while (!in_ready);
    predict_request(r);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN) bound_min = value;
    else bound_max = value;
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   live [$];
    r = req_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 5) r.opcode = 2'd3;
    else if (pick < 45) r.opcode = OP_TICK;
    else if (pick < 80) r.opcode = OP_CREATE;
    else r.opcode = OP_DELETE;
    if (r.opcode == OP_TICK) begin
      if ($urandom_range(0, 19) == 0) epoch = epoch - 32'($urandom_range(1, 300));
      else epoch = epoch + 32'($urandom_range(0, 150));
    end
    r.now_seconds = epoch;
    r.local_hour = 5'((epoch / 3600) % 24);
    r.local_minute = 6'((epoch / 60) % 60);
    r.local_second = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 60))
                                                  : 6'(epoch % 60);
    r.clock_synced = ($urandom_range(0, 9) != 0);
    r.action_tag = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    if (r.schedule_kind == KIND_DAILY) begin
      if ($urandom_range(0, 6) == 0) begin
        r.period_or_hour = 16'($urandom_range(0, 31));
        r.minute_of_hour = 8'($urandom_range(0, 255));
      end else begin
        r.period_or_hour = 16'(r.local_hour);
        r.minute_of_hour = 8'((r.local_minute + $urandom_range(0, 2)) % 60);
      end
    end else if ($urandom_range(0, 9) != 0) begin
      r.period_or_hour = 16'($urandom_range(0, 4));
    end
    if (r.opcode == OP_DELETE && $urandom_range(0, 9) < 7) begin
      for (int i = 0; i < SLOTS; i++)
        if (shadow[i].alarm_id != 8'd0) live.push_back(i);
      if (live.size() != 0)
        r.entry_id = shadow[live[$urandom_range(0, live.size() - 1)]].alarm_id;
    end
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] op, logic [31:0] now, logic [4:0] hh,
                                    logic [5:0] mm, logic [5:0] ss, logic sync,
                                    logic [1:0] kind, logic [15:0] ioh, logic [7:0] moh,
                                    logic [7:0] eid, logic [15:0] act, logic typed,
                                    logic [2:0] k, logic [7:0] id);
    stim_row_t s;
    s.req = {op, now, hh, mm, ss, sync, kind, ioh, moh, eid, act};
    s.typed = typed;
    s.want_kind = k;
    s.want_id = id;
    return s;
  endfunction

  // receiver: random stalls, with stretches of none
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alarm_word_t got;
    alarm_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = {result_kind, alarm_id, fired_action, last_of_run};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word kind=%0d id=%0d act=%0d last=%0d",
                                       got.kind, got.id, got.action, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.kind, want.id, want.action, want.last,
                     got.kind, got.id, got.action, got.last);
        end
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    logic [15:0] bounds [4][2];
    in_valid = 1'b0;
    {opcode, now_seconds, local_hour, local_minute, local_second, clock_synced,
     schedule_kind, period_or_hour, minute_of_hour, entry_id, action_tag} = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN;
    cfg_data = 16'd0;
    rst = 1'b1;
    mismatches = 0;
    burst_left = 0;
    gap_max = 4;
    stall_on = 1'b1;
    bound_min = 16'd1;
    bound_max = 16'd65535;
    epoch = $urandom;
    for (int i = 0; i < SLOTS; i++) shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(row(OP_TICK, 32'd100, 5'd0, 6'd1, 6'd40, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_PERIODIC,
                           16'd5, 8'd0, 8'd0, 16'd0, 1'b1, RES_REJECTED, 8'd0));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd7, 1'b1, RES_REJECTED, 8'd0));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_PERIODIC,
                           16'hFFFF, 8'd0, 8'd0, 16'hFFFF, 1'b1, RES_CREATED, 8'd1));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_DAILY,
                           16'd24, 8'd0, 8'd0, 16'd3, 1'b1, RES_REJECTED, 8'd0));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_DAILY,
                           16'd23, 8'd60, 8'd0, 16'd3, 1'b1, RES_REJECTED, 8'd0));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_DAILY,
                           16'd23, 8'd59, 8'd0, 16'd2, 1'b1, RES_CREATED, 8'd2));
    directed.push_back(row(OP_CREATE, 32'd100, 5'd0, 6'd0, 6'd0, 1'b1, KIND_CONDITION,
                           16'hFFFF, 8'hFF, 8'd0, 16'd9, 1'b1, RES_CREATED, 8'd3));
    directed.push_back(row(OP_CREATE, 32'd1000, 5'd0, 6'd0, 6'd0, 1'b1, KIND_ONESHOT,
                           16'd1, 8'd0, 8'd0, 16'd4, 1'b1, RES_CREATED, 8'd4));
    directed.push_back(row(OP_DELETE, 32'd0, 5'd0, 6'd0, 6'd0, 1'b0, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b1, RES_DELETED, 8'd0));
    directed.push_back(row(OP_DELETE, 32'd0, 5'd0, 6'd0, 6'd0, 1'b0, KIND_PERIODIC,
                           16'd0, 8'd0, 8'hFF, 16'd0, 1'b1, RES_NOT_FOUND, 8'd0));
    // clock behind the one-shot stamp: nothing fires
    directed.push_back(row(OP_TICK, 32'd500, 5'd0, 6'd8, 6'd20, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_TICK, 32'd1060, 5'd0, 6'd17, 6'd40, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_TICK, 32'd86399, 5'd23, 6'd59, 6'd59, 1'b0, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_TICK, 32'd86399, 5'd23, 6'd59, 6'd60, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_TICK, 32'd86400, 5'd23, 6'd59, 6'd0, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    // start of minute wraps below zero
    directed.push_back(row(OP_TICK, 32'd5, 5'd23, 6'd59, 6'd30, 1'b1, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd0, 16'd0, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(2'd3, 32'hFFFFFFFF, 5'd23, 6'd59, 6'd60, 1'b1, KIND_ONESHOT,
                           16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, RES_FIRED, 8'd0));
    directed.push_back(row(OP_DELETE, 32'd0, 5'd0, 6'd0, 6'd0, 1'b0, KIND_PERIODIC,
                           16'd0, 8'd0, 8'd2, 16'd0, 1'b1, RES_DELETED, 8'd2));
    directed.push_back(row(OP_CREATE, 32'hFFFFFFFF, 5'd0, 6'd0, 6'd0, 1'b1, KIND_ONESHOT,
                           16'd1, 8'd0, 8'd0, 16'd5, 1'b0, RES_CREATED, 8'd0));

    foreach (directed[n]) begin
      send_request(directed[n].req);
      if (directed[n].typed) begin
        pending_words[$].kind = directed[n].want_kind;
        pending_words[$].id = directed[n].want_id;
      end
    end
    settle_idle();

    bounds = '{'{16'd0, 16'd65535}, '{16'd20, 16'd3}, '{16'd1, 16'd3}, '{16'd0, 16'd0}};
    for (int ph = 0; ph < 4; ph++) begin
      write_bound(CFG_MIN, bounds[ph][0]);
      write_bound(CFG_MAX, bounds[ph][1]);
      stall_on = (ph != 2);
      gap_max = (ph == 1) ? 0 : 6;
      for (int n = 0; n < 80; n++) send_request(random_request());
      settle_idle();
    end

    fork
      while (pending_words.size() != 0) @(posedge clk);
      repeat (200000) @(posedge clk);
    join_any
    disable fork;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("scheduled_alarm_table_top verification clean");
    end else begin
      $display("scheduled_alarm_table_top verification failed");
    end
    $finish;
  end

endmodule

// ----- scheduled_alarm_table_top.f -----
+incdir+rtl/core
rtl/core/sat_pkg.sv
rtl/core/sat_cell.sv
rtl/core/sat_eval.sv
rtl/core/scheduled_alarm_table_top.sv
rtl/core/sat_chk.sv
bench/tb.sv
